### rtl/core/pic_particle_push_deposit_core_assert.svh
// ----------------------------------------------------------------------------
// PIC push/deposit core assertion macros
// Shared concurrent assertion forms for the core checkers.
// ----------------------------------------------------------------------------
`ifndef PIC_PARTICLE_PUSH_DEPOSIT_CORE_ASSERT_SVH
`define PIC_PARTICLE_PUSH_DEPOSIT_CORE_ASSERT_SVH

// same-cycle implication
`define PPD_AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ppd assertion failed");

// next-cycle implication
`define PPD_AST_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ppd assertion failed");

`endif

### rtl/core/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Types, constants and arithmetic helpers of the PIC push/deposit core.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int N_GRID = 1024;
  localparam int CELL_W = $clog2(N_GRID);
  localparam int FRAC   = 24;
  localparam int G_W    = 49;

  localparam logic [G_W-1:0] TOP_G = G_W'(N_GRID - 1) << FRAC;
  localparam logic [24:0]    ONE_Q = 25'd1 << FRAC;

  localparam logic [1:0] CMD_WR_FIELD = 2'd0;
  localparam logic [1:0] CMD_WR_DENS  = 2'd1;
  localparam logic [1:0] CMD_PUSH     = 2'd2;
  localparam logic [1:0] CMD_RD_DENS  = 2'd3;

  localparam logic [1:0] DEST_STAY  = 2'd0;
  localparam logic [1:0] DEST_BELOW = 2'd1;
  localparam logic [1:0] DEST_ABOVE = 2'd2;

  localparam logic [2:0] CFG_LEFT  = 3'd0;
  localparam logic [2:0] CFG_RIGHT = 3'd1;
  localparam logic [2:0] CFG_ICW   = 3'd2;
  localparam logic [2:0] CFG_QM    = 3'd3;
  localparam logic [2:0] CFG_DT    = 3'd4;
  localparam logic [2:0] CFG_CHG   = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         grid_index;
    logic signed [31:0] grid_value;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic [1:0]         destination;
    logic signed [31:0] read_value;
  } res_t;

  // a + floor(p / 2^24), saturated to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [65:0] p);
    logic signed [66:0] s;
    s = 67'(a) + 67'(p >>> FRAC);
    if (s > 67'sd2147483647) return 32'sh7fffffff;
    if (s < -67'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

### rtl/core/ppd_ram.sv
// ----------------------------------------------------------------------------
// ppd_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
module ppd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### rtl/core/ppd_front.sv
// ----------------------------------------------------------------------------
// ppd_front
// Input side: takes command words into a two-entry queue.
// ----------------------------------------------------------------------------
module ppd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ppd_pkg::cmd_t       din,
  output logic                full,
  input  logic                take,
  output logic                valid,
  output ppd_pkg::cmd_t       dout
);

  ppd_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];
  assign do_wr = push && !full;
  assign do_rd = take && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 2'd1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= din;
  end

endmodule

### rtl/core/ppd_resq.sv
// ----------------------------------------------------------------------------
// ppd_resq
// Result side: two-entry queue of result words.
// ----------------------------------------------------------------------------
module ppd_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppd_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ppd_pkg::res_t dout
);

  ppd_pkg::res_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 2'd1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= din;
  end

endmodule

### rtl/core/ppd_back.sv
// ----------------------------------------------------------------------------
// ppd_back
// Execution sequencer: grid RAMs, config registers, one shared multiplier.
// ----------------------------------------------------------------------------
module ppd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic                cmd_valid,
  input  ppd_pkg::cmd_t       cmd,
  output logic                cmd_take,
  input  logic                res_full,
  output logic                res_push,
  output ppd_pkg::res_t       res
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WR   = 5'd1;
  localparam logic [4:0] S_RD0  = 5'd2;
  localparam logic [4:0] S_RD1  = 5'd3;
  localparam logic [4:0] S_OUT  = 5'd4;
  localparam logic [4:0] S_GC0  = 5'd5;
  localparam logic [4:0] S_GC1  = 5'd6;
  localparam logic [4:0] S_GC2  = 5'd7;
  localparam logic [4:0] S_GC3  = 5'd8;
  localparam logic [4:0] S_F0   = 5'd9;
  localparam logic [4:0] S_F1   = 5'd10;
  localparam logic [4:0] S_F2   = 5'd11;
  localparam logic [4:0] S_F3   = 5'd12;
  localparam logic [4:0] S_F4   = 5'd13;
  localparam logic [4:0] S_V0   = 5'd14;
  localparam logic [4:0] S_V1   = 5'd15;
  localparam logic [4:0] S_X0   = 5'd16;
  localparam logic [4:0] S_X1   = 5'd17;
  localparam logic [4:0] S_CMP  = 5'd18;
  localparam logic [4:0] S_DP0  = 5'd19;
  localparam logic [4:0] S_DP1  = 5'd20;
  localparam logic [4:0] S_DP2  = 5'd21;
  localparam logic [4:0] S_DP3  = 5'd22;

  localparam int CW = ppd_pkg::CELL_W;

  // config
  logic signed [31:0] left_r, right_r, qm_r, dt_r, chg_r;
  logic [31:0]        icw_r;

  // sequencer state
  logic [4:0]          state_r, state_nxt;
  ppd_pkg::cmd_t       cmd_r, cmd_nxt;
  logic                phase_r, phase_nxt;
  logic [31:0]         ud_r, ud_nxt;
  logic signed [65:0]  acc_r, acc_nxt;
  logic signed [65:0]  prod_r;
  logic [CW-1:0]       cell_r, cell_nxt;
  logic [24:0]         frac_r, frac_nxt;
  logic signed [31:0]  f0_r, f0_nxt, e_r, e_nxt, v_r, v_nxt, x_r, x_nxt;
  logic signed [31:0]  rdval_r, rdval_nxt;
  logic [1:0]          dest_r, dest_nxt;

  logic signed [32:0]  mul_a, mul_b;
  logic signed [32:0]  d;
  logic [ppd_pkg::G_W-1:0] g_sum, g_cl;
  logic signed [65:0]  esum;
  logic                in_grid, is_push, is_rd;

  logic          fram_we, dram_we;
  logic [CW-1:0] fram_addr, dram_addr;
  logic [31:0]   fram_wdata, dram_wdata, fram_rdata, dram_rdata;

  ppd_ram #(.WIDTH(32), .DEPTH(ppd_pkg::N_GRID)) u_field (
    .clk(clk), .we(fram_we), .addr(fram_addr), .wdata(fram_wdata), .rdata(fram_rdata)
  );

  ppd_ram #(.WIDTH(32), .DEPTH(ppd_pkg::N_GRID)) u_dens (
    .clk(clk), .we(dram_we), .addr(dram_addr), .wdata(dram_wdata), .rdata(dram_rdata)
  );

  assign in_grid = ({22'd0, cmd_r.grid_index} < 32'(ppd_pkg::N_GRID));
  assign is_push = (cmd_r.command == ppd_pkg::CMD_PUSH);
  assign is_rd   = (cmd_r.command == ppd_pkg::CMD_RD_DENS);

  assign d     = {x_r[31], x_r} - {left_r[31], left_r};
  assign g_sum = acc_r[ppd_pkg::G_W-1:0] + ppd_pkg::G_W'(prod_r[47:16]);
  assign g_cl  = (g_sum > ppd_pkg::TOP_G) ? ppd_pkg::TOP_G : g_sum;
  assign esum  = acc_r + prod_r;

  assign res.new_position = is_push ? x_r : 32'sd0;
  assign res.new_velocity = is_push ? v_r : 32'sd0;
  assign res.destination  = is_push ? dest_r : ppd_pkg::DEST_STAY;
  assign res.read_value   = is_rd ? rdval_r : 32'sd0;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    phase_nxt  = phase_r;
    ud_nxt     = ud_r;
    acc_nxt    = acc_r;
    cell_nxt   = cell_r;
    frac_nxt   = frac_r;
    f0_nxt     = f0_r;
    e_nxt      = e_r;
    v_nxt      = v_r;
    x_nxt      = x_r;
    rdval_nxt  = rdval_r;
    dest_nxt   = dest_r;
    mul_a      = '0;
    mul_b      = '0;
    fram_we    = 1'b0;
    dram_we    = 1'b0;
    fram_addr  = cell_r;
    dram_addr  = cell_r;
    fram_wdata = cmd_r.grid_value;
    dram_wdata = cmd_r.grid_value;
    cmd_take   = 1'b0;
    res_push   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // one result per command, so room at start stays until the push
        if (cmd_valid && !res_full) begin
          cmd_take  = 1'b1;
          cmd_nxt   = cmd;
          x_nxt     = cmd.position;
          v_nxt     = cmd.velocity;
          phase_nxt = 1'b0;
          rdval_nxt = 32'sd0;
          unique case (cmd.command)
            ppd_pkg::CMD_PUSH:    state_nxt = S_GC0;
            ppd_pkg::CMD_RD_DENS: state_nxt = S_RD0;
            default:              state_nxt = S_WR;
          endcase
        end
      end
      S_WR: begin
        fram_addr = CW'(cmd_r.grid_index);
        dram_addr = CW'(cmd_r.grid_index);
        if (in_grid) begin
          if (cmd_r.command == ppd_pkg::CMD_WR_FIELD) fram_we = 1'b1;
          else dram_we = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_RD0: begin
        dram_addr = CW'(cmd_r.grid_index);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        rdval_nxt = in_grid ? dram_rdata : 32'sd0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      // grid coordinate: (x - left) * icw, split into two 32x16 products
      S_GC0: begin
        ud_nxt    = (d > 0) ? d[31:0] : 32'd0;
        state_nxt = S_GC1;
      end
      S_GC1: begin
        mul_a     = {1'b0, ud_r};
        mul_b     = {17'd0, icw_r[31:16]};
        state_nxt = S_GC2;
      end
      S_GC2: begin
        acc_nxt   = prod_r;
        mul_a     = {1'b0, ud_r};
        mul_b     = {17'd0, icw_r[15:0]};
        state_nxt = S_GC3;
      end
      S_GC3: begin
        if (g_cl >= ppd_pkg::TOP_G) begin
          cell_nxt = CW'(ppd_pkg::N_GRID - 2);
          frac_nxt = ppd_pkg::ONE_Q;
        end else begin
          cell_nxt = g_cl[ppd_pkg::FRAC +: CW];
          frac_nxt = {1'b0, g_cl[ppd_pkg::FRAC-1:0]};
        end
        state_nxt = phase_r ? S_DP0 : S_F0;
      end
      S_F0: begin
        state_nxt = S_F1;
      end
      S_F1: begin
        fram_addr = cell_r + 1'b1;
        f0_nxt    = fram_rdata;
        state_nxt = S_F2;
      end
      S_F2: begin
        mul_a     = {8'd0, frac_r};
        mul_b     = {fram_rdata[31], fram_rdata};
        state_nxt = S_F3;
      end
      S_F3: begin
        acc_nxt   = prod_r;
        mul_a     = {8'd0, ppd_pkg::ONE_Q - frac_r};
        mul_b     = {f0_r[31], f0_r};
        state_nxt = S_F4;
      end
      S_F4: begin
        e_nxt     = esum[55:24];
        state_nxt = S_V0;
      end
      S_V0: begin
        mul_a     = {qm_r[31], qm_r};
        mul_b     = {e_r[31], e_r};
        state_nxt = S_V1;
      end
      S_V1: begin
        v_nxt     = ppd_pkg::sat_add(v_r, prod_r);
        state_nxt = S_X0;
      end
      S_X0: begin
        mul_a     = {v_r[31], v_r};
        mul_b     = {dt_r[31], dt_r};
        state_nxt = S_X1;
      end
      S_X1: begin
        x_nxt     = ppd_pkg::sat_add(x_r, prod_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (x_r > left_r && x_r < right_r) begin
          dest_nxt  = ppd_pkg::DEST_STAY;
          phase_nxt = 1'b1;
          state_nxt = S_GC0;
        end else if (x_r < left_r) begin
          dest_nxt  = ppd_pkg::DEST_BELOW;
          state_nxt = S_OUT;
        end else begin
          dest_nxt  = ppd_pkg::DEST_ABOVE;
          state_nxt = S_OUT;
        end
      end
      // deposit: read-modify-write of the two neighbor points
      S_DP0: begin
        mul_a     = {chg_r[31], chg_r};
        mul_b     = {8'd0, ppd_pkg::ONE_Q - frac_r};
        state_nxt = S_DP1;
      end
      S_DP1: begin
        dram_we    = 1'b1;
        dram_wdata = ppd_pkg::sat_add(dram_rdata, prod_r);
        mul_a      = {chg_r[31], chg_r};
        mul_b      = {8'd0, frac_r};
        state_nxt  = S_DP2;
      end
      S_DP2: begin
        dram_addr = cell_r + 1'b1;
        mul_a     = {chg_r[31], chg_r};
        mul_b     = {8'd0, frac_r};
        state_nxt = S_DP3;
      end
      S_DP3: begin
        dram_addr  = cell_r + 1'b1;
        dram_we    = 1'b1;
        dram_wdata = ppd_pkg::sat_add(dram_rdata, prod_r);
        state_nxt  = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= 32'sd0;
      right_r <= 32'sd16777216;
      icw_r   <= 32'd65536;
      qm_r    <= 32'sd0;
      dt_r    <= 32'sd0;
      chg_r   <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ppd_pkg::CFG_LEFT:  left_r  <= cfg_wdata;
          ppd_pkg::CFG_RIGHT: right_r <= cfg_wdata;
          ppd_pkg::CFG_ICW:   icw_r   <= cfg_wdata;
          ppd_pkg::CFG_QM:    qm_r    <= cfg_wdata;
          ppd_pkg::CFG_DT:    dt_r    <= cfg_wdata;
          ppd_pkg::CFG_CHG:   chg_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    phase_r <= phase_nxt;
    ud_r    <= ud_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= mul_a * mul_b;
    cell_r  <= cell_nxt;
    frac_r  <= frac_nxt;
    f0_r    <= f0_nxt;
    e_r     <= e_nxt;
    v_r     <= v_nxt;
    x_r     <= x_nxt;
    rdval_r <= rdval_nxt;
    dest_r  <= dest_nxt;
  end

endmodule

### rtl/core/pic_particle_push_deposit_core.sv
// ----------------------------------------------------------------------------
// pic_particle_push_deposit_core
// 1-D particle push with linear field gather and two-point charge deposit.
// ----------------------------------------------------------------------------
// Usage:
//   Input words go in with in_push while in_full is low; each carries a
//   command (field write, density write, push, density read).
//   Every command gives one result word, shown while out_empty is low and
//   taken with out_pop; results come out in command order.
//   Config registers are written through cfg_we/cfg_addr/cfg_wdata while idle.
// Structure:
//   Writes, reads, pushes that leave the domain and pushes that deposit each
//   step through sequencer states that share one 33x33 multiplier and the
//   single port of each grid RAM.
//   A two-word input queue and a two-word result queue decouple both sides;
//   a stalled receiver stops the sequencer only once the result queue is full.
// Reset:
//   Queues empty, config to defaults; grid RAM contents stay undefined until
//   written.
// ----------------------------------------------------------------------------
module pic_particle_push_deposit_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [9:0]         in_grid_index,
  input  logic signed [31:0] in_grid_value,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_velocity,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [31:0] out_new_position,
  output logic signed [31:0] out_new_velocity,
  output logic [1:0]         out_destination,
  output logic signed [31:0] out_read_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  ppd_pkg::cmd_t in_word, cmd_word;
  ppd_pkg::res_t res_word, out_word;
  logic          cmd_valid, cmd_take, res_full, res_push;

  assign in_word.command    = in_command;
  assign in_word.grid_index = in_grid_index;
  assign in_word.grid_value = in_grid_value;
  assign in_word.position   = in_position;
  assign in_word.velocity   = in_velocity;

  ppd_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .din(in_word), .full(in_full),
    .take(cmd_take), .valid(cmd_valid), .dout(cmd_word)
  );

  ppd_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .cmd_valid(cmd_valid), .cmd(cmd_word),
    .cmd_take(cmd_take), .res_full(res_full), .res_push(res_push), .res(res_word)
  );

  ppd_resq u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res_word), .full(res_full),
    .pop(out_pop), .empty(out_empty), .dout(out_word)
  );

  assign out_new_position = out_word.new_position;
  assign out_new_velocity = out_word.new_velocity;
  assign out_destination  = out_word.destination;
  assign out_read_value   = out_word.read_value;

endmodule

### rtl/core/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker
// Port-level checks of the PIC push/deposit core, bound to the top level.
// ----------------------------------------------------------------------------
`include "pic_particle_push_deposit_core_assert.svh"

module ppd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_pop,
  input logic               out_empty,
  input logic signed [31:0] out_new_position,
  input logic signed [31:0] out_new_velocity,
  input logic [1:0]         out_destination,
  input logic signed [31:0] out_read_value
);

  // result queue comes out of reset empty, input queue not full
  `PPD_AST_NXT(a_rst_empty, clk, 1'b1, !rst_n, out_empty)
  `PPD_AST_NXT(a_rst_notfull, clk, 1'b1, !rst_n, !in_full)

  // waiting word holds until popped
  `PPD_AST_NXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_new_position) && $stable(out_new_velocity) && $stable(out_read_value))

  `PPD_AST_IMP(a_dest_code, clk, rst_n, !out_empty, out_destination != 2'd3)

endmodule

bind pic_particle_push_deposit_core ppd_checker u_ppd_checker (.*);

### sim/pic_particle_push_deposit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_particle_push_deposit_core_tb
// Self-checking bench: drives grid writes, density reads and particle pushes,
// predicts each result word from a behavioral copy of the grids and config,
// and compares every popped word in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module pic_particle_push_deposit_core_tb;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          FILL_LO      = 64;
  localparam logic [48:0] G_TOP = 49'(ppd_pkg::N_GRID - 1) << ppd_pkg::FRAC;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_command = ppd_pkg::CMD_WR_FIELD;
  logic [9:0]         in_grid_index = '0;
  logic signed [31:0] in_grid_value = '0;
  logic signed [31:0] in_position = '0;
  logic signed [31:0] in_velocity = '0;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic signed [31:0] out_new_position;
  logic signed [31:0] out_new_velocity;
  logic [1:0]         out_destination;
  logic signed [31:0] out_read_value;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = ppd_pkg::CFG_LEFT;
  logic [31:0]        cfg_wdata = '0;

  pic_particle_push_deposit_core i_dut (.*);

  always #1 clk = ~clk;

  // behavioral state
  logic signed [31:0] field_mem [ppd_pkg::N_GRID];
  logic signed [31:0] dens_mem [ppd_pkg::N_GRID];
  bit                 field_ok [ppd_pkg::N_GRID];
  bit                 dens_ok [ppd_pkg::N_GRID];
  logic signed [31:0] left_edge, right_edge, qm_factor, dt_step, chg_scale;
  logic [31:0]        icw;

  ppd_pkg::res_t expected_words [$];
  int            mismatches = 0;
  longint        cycles = 0;
  int            stall_cnt = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    mismatches++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
  endtask

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // grid coordinate: grid point and Q1.24 weight (weight may be 1.0)
  task automatic locate(input logic signed [31:0] x, output int pt,
                        output logic [24:0] frac);
    logic signed [33:0] d;
    logic [48:0]        g;
    d = 34'(x) - 34'(left_edge);
    g = '0;
    if (d > 0)
      g = 49'(64'(d[32:0]) * icw[31:16] + ((64'(d[32:0]) * icw[15:0]) >> 16));
    if (g > G_TOP) g = G_TOP;
    pt = int'(g >> ppd_pkg::FRAC);
    frac = {1'b0, g[23:0]};
    if (pt >= ppd_pkg::N_GRID - 1) begin
      pt = ppd_pkg::N_GRID - 2;
      frac = ppd_pkg::ONE_Q;
    end
  endtask

  function automatic logic signed [31:0] fl24(input logic signed [66:0] v);
    logic signed [66:0] s;
    s = v >>> ppd_pkg::FRAC;
    return s[31:0];
  endfunction

  // moderate field values keep most particles near the filled grid points
  function automatic logic signed [31:0] field_val();
    logic signed [31:0] r;
    r = $urandom;
    return r >>> 6;
  endfunction

  // gather, velocity and position update of one push
  task automatic push_math(input logic signed [31:0] x0, input logic signed [31:0] v0,
                           output int gpt, output logic signed [31:0] v,
                           output logic signed [31:0] x, output bit stays,
                           output int dpt, output logic [24:0] df);
    logic [24:0]        f;
    logic signed [66:0] acc;
    logic signed [31:0] e;
    locate(x0, gpt, f);
    acc = 67'($signed({1'b0, f})) * field_mem[gpt + 1]
        + 67'($signed(26'(ppd_pkg::ONE_Q) - 26'(f))) * field_mem[gpt];
    e = sat32(acc >>> ppd_pkg::FRAC);
    v = sat32(67'(v0) + (67'(67'(qm_factor) * e) >>> ppd_pkg::FRAC));
    x = sat32(67'(x0) + (67'(67'(v) * dt_step) >>> ppd_pkg::FRAC));
    stays = (x > left_edge) && (x < right_edge);
    dpt = 0;
    df = '0;
    if (stays) locate(x, dpt, df);
  endtask

  task automatic predict(input logic [1:0] cmd, input logic [9:0] idx,
                         input logic signed [31:0] gv, input logic signed [31:0] x0,
                         input logic signed [31:0] v0);
    ppd_pkg::res_t      r;
    int                 gpt, dpt;
    logic [24:0]        df;
    logic signed [31:0] v, x;
    bit                 stays;
    r = '0;
    case (cmd)
      ppd_pkg::CMD_WR_FIELD: begin field_mem[idx] = gv; field_ok[idx] = 1'b1; end
      ppd_pkg::CMD_WR_DENS: begin dens_mem[idx] = gv; dens_ok[idx] = 1'b1; end
      ppd_pkg::CMD_RD_DENS: r.read_value = dens_mem[idx];
      default: begin
        push_math(x0, v0, gpt, v, x, stays, dpt, df);
        if (stays) begin
          r.destination = ppd_pkg::DEST_STAY;
          dens_mem[dpt] = sat32(67'(dens_mem[dpt]) + 67'(fl24(
            67'(chg_scale) * 67'($signed(26'(ppd_pkg::ONE_Q) - 26'(df))))));
          dens_mem[dpt + 1] = sat32(67'(dens_mem[dpt + 1]) + 67'(fl24(
            67'(chg_scale) * 67'($signed({1'b0, df})))));
        end else if (x < left_edge) r.destination = ppd_pkg::DEST_BELOW;
        else r.destination = ppd_pkg::DEST_ABOVE;
        r.new_position = x;
        r.new_velocity = v;
      end
    endcase
    expected_words.push_back(r);
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return int'($urandom_range(10, 40));
    return int'($urandom_range(1, 3));
  endfunction

  bit gaps_on = 1;

  // in_push stays high across back-to-back words; drain() drops it
  task automatic send_raw(input logic [1:0] cmd, input logic [9:0] idx,
                          input logic signed [31:0] gv, input logic signed [31:0] x,
                          input logic signed [31:0] v);
    int n;
    n = gaps_on ? gap_len() : 0;
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_push <= 1'b1;
    in_command <= cmd;
    in_grid_index <= idx;
    in_grid_value <= gv;
    in_position <= x;
    in_velocity <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict(cmd, idx, gv, x, v);
  endtask

  // write any grid entry the word would read before it is sent
  task automatic make_ready(input logic [1:0] cmd, input logic [9:0] idx,
                            input logic signed [31:0] x0, input logic signed [31:0] v0);
    int                 gpt, dpt;
    logic [24:0]        f, df;
    logic signed [31:0] v, x;
    bit                 stays;
    if (cmd == ppd_pkg::CMD_RD_DENS) begin
      if (!dens_ok[idx]) send_raw(ppd_pkg::CMD_WR_DENS, idx, $urandom, 0, 0);
    end else if (cmd == ppd_pkg::CMD_PUSH) begin
      locate(x0, gpt, f);
      for (int k = 0; k < 2; k++)
        if (!field_ok[gpt + k])
          send_raw(ppd_pkg::CMD_WR_FIELD, 10'(gpt + k), field_val(), 0, 0);
      push_math(x0, v0, gpt, v, x, stays, dpt, df);
      if (stays)
        for (int k = 0; k < 2; k++)
          if (!dens_ok[dpt + k])
            send_raw(ppd_pkg::CMD_WR_DENS, 10'(dpt + k), $urandom, 0, 0);
    end
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [9:0] idx,
                           input logic signed [31:0] gv, input logic signed [31:0] x,
                           input logic signed [31:0] v);
    make_ready(cmd, idx, x, v);
    send_raw(cmd, idx, gv, x, v);
  endtask

  // result checker with random stalls, a few of them long
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        ppd_pkg::res_t r;
        r = expected_words.pop_front();
        if (out_new_position !== r.new_position)
          report("new_position", out_new_position, r.new_position);
        if (out_new_velocity !== r.new_velocity)
          report("new_velocity", out_new_velocity, r.new_velocity);
        if (out_destination !== r.destination)
          report("destination", out_destination, r.destination);
        if (out_read_value !== r.read_value)
          report("read_value", out_read_value, r.read_value);
      end
    end
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_pop <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      stall_cnt <= int'($urandom_range(10, 40));
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic drain();
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] a, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    case (a)
      ppd_pkg::CFG_LEFT: left_edge = d;
      ppd_pkg::CFG_RIGHT: right_edge = d;
      ppd_pkg::CFG_ICW: icw = d;
      ppd_pkg::CFG_QM: qm_factor = d;
      ppd_pkg::CFG_DT: dt_step = d;
      default: chg_scale = d;
    endcase
  endtask

  task automatic set_all(input logic [31:0] l, input logic [31:0] r, input logic [31:0] w,
                         input logic [31:0] q, input logic [31:0] t, input logic [31:0] c);
    drain();
    set_reg(ppd_pkg::CFG_LEFT, l);
    set_reg(ppd_pkg::CFG_RIGHT, r);
    set_reg(ppd_pkg::CFG_ICW, w);
    set_reg(ppd_pkg::CFG_QM, q);
    set_reg(ppd_pkg::CFG_DT, t);
    set_reg(ppd_pkg::CFG_CHG, c);
    cfg_we <= 1'b0;
  endtask

  // low grid points and the top pair up front; others are written on first use
  task automatic test_grid_fill();
    for (int i = 0; i < FILL_LO; i++) begin
      send_word(ppd_pkg::CMD_WR_FIELD, 10'(i), field_val(), 0, 0);
      send_word(ppd_pkg::CMD_WR_DENS, 10'(i), $urandom, 0, 0);
    end
    for (int i = ppd_pkg::N_GRID - 2; i < ppd_pkg::N_GRID; i++) begin
      send_word(ppd_pkg::CMD_WR_FIELD, 10'(i), field_val(), 0, 0);
      send_word(ppd_pkg::CMD_WR_DENS, 10'(i), $urandom, 0, 0);
    end
  endtask

  task automatic test_directed();
    set_all(32'h0, 32'h0100_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_word(ppd_pkg::CMD_WR_FIELD, 10'd0, 32'sh7fffffff, 0, 0);
    send_word(ppd_pkg::CMD_WR_FIELD, 10'd1, 32'sh80000000, 0, 0);
    send_word(ppd_pkg::CMD_WR_DENS, 10'd1023, 32'sh7fffff00, 0, 0);
    send_word(ppd_pkg::CMD_RD_DENS, 10'd1023, 0, 0, 0);
    send_word(ppd_pkg::CMD_RD_DENS, 10'd0, 0, 0, 0);
    set_all(32'hF000_0000, 32'h1000_0000, 32'h0001_0000, 32'h0100_0000,
            32'h0100_0000, 32'h7fff_ffff);
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh0080_0000, 32'sh0);
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh7fffffff, 32'sh7fffffff);   // saturating
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh80000000, 32'sh80000000);
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'shF000_0000, 32'sh0);          // exactly at left
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh1000_0000, 32'sh0);          // exactly at right
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh0FFF_FFFF, 32'sh0);          // just below right
    send_word(ppd_pkg::CMD_RD_DENS, 10'd1022, 0, 0, 0);
    // empty domain
    set_all(32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000);
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh0100_0000, 32'sh0000_1000);
    // zero cell-width reciprocal
    set_all(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0100_0000, 32'h0080_0000,
            32'h8000_0000);
    send_word(ppd_pkg::CMD_PUSH, 0, 0, 32'sh1234_5678, 32'sh0100_0000);
    send_word(ppd_pkg::CMD_RD_DENS, 10'd0, 0, 0, 0);
    send_word(ppd_pkg::CMD_RD_DENS, 10'd1, 0, 0, 0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      int k;
      logic signed [31:0] x, v;
      k = $urandom_range(0, 9);
      x = (k < 6) ? $signed(32'(left_edge) + $urandom_range(0, 32'h0400_0000)) : $urandom;
      v = (k < 7) ? $signed(32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000) : $urandom;
      case ($urandom_range(0, 9))
        0: send_word(ppd_pkg::CMD_WR_FIELD, 10'($urandom), field_val(), x, v);
        1: send_word(ppd_pkg::CMD_WR_DENS, 10'($urandom), $urandom, x, v);
        2, 3: send_word(ppd_pkg::CMD_RD_DENS, 10'($urandom_range(0, FILL_LO - 1)),
                        $urandom, x, v);
        default: send_word(ppd_pkg::CMD_PUSH, 10'($urandom), $urandom, x, v);
      endcase
    end
  endtask

  task automatic test_config_sweep();
    for (int p = 0; p < 4; p++) begin
      set_all($signed(32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000),
              32'h7000_0000 >> $urandom_range(0, 4), 32'h0001_0000 << $urandom_range(0, 3),
              $urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0100_0000),
              $urandom);
      test_random(80);
      if (p == 1) begin
        gaps_on = 0;           // back-to-back burst, then wait for the pipe to empty
        test_random(50);
        drain();
        gaps_on = 1;
      end
    end
    set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(120);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    left_edge = 0; right_edge = 32'h0100_0000; icw = 32'h0001_0000;
    qm_factor = 0; dt_step = 0; chg_scale = 0;
    @(posedge clk);
    gaps_on = 0;
    test_grid_fill();
    gaps_on = 1;
    test_directed();
    test_config_sweep();
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
